// ===== rtl/core/ptw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_pkg
// Types and constants shared by the four-level page-table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

   localparam int VIRT_ADDR_BITS = 48;
   localparam int RA_BITS        = 36;
   localparam int PA_BITS        = 52;
   localparam int ENTRY_BITS     = 64;
   localparam int IDX_BITS       = 9;

   localparam logic [ENTRY_BITS-1:0] OFFSET_4K_MASK = 64'h0000_0000_0000_0FFF;
   localparam logic [ENTRY_BITS-1:0] OFFSET_2M_MASK = 64'h0000_0000_001F_FFFF;
   localparam logic [ENTRY_BITS-1:0] OFFSET_1G_MASK = 64'h0000_0000_3FFF_FFFF;

   localparam int ENTRY_PRESENT_BIT = 0;
   localparam int ENTRY_PS_BIT      = 7;

   localparam logic ACT_REQUEST  = 1'b0;
   localparam logic ACT_RESPONSE = 1'b1;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   localparam logic [1:0] PS_4K = 2'd0;
   localparam logic [1:0] PS_2M = 2'd1;
   localparam logic [1:0] PS_1G = 2'd2;

   localparam logic [1:0] LVL_PML4 = 2'd0;
   localparam logic [1:0] LVL_PDPT = 2'd1;
   localparam logic [1:0] LVL_PD   = 2'd2;
   localparam logic [1:0] LVL_PT   = 2'd3;

   typedef struct packed {
      logic                      action;
      logic [RA_BITS-1:0]        table_root;
      logic [VIRT_ADDR_BITS-1:0] virtual_address;
      logic [ENTRY_BITS-1:0]     read_data;
      logic                      read_error;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [RA_BITS-1:0] read_address;
      logic [PA_BITS-1:0] physical_address;
      logic               fault;
      logic [1:0]         map_size;
   } rsp_type;

endpackage

// ===== rtl/core/ptw_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_req_if
// Request channel: new translations and memory read responses.
// ----------------------------------------------------------------------------
interface ptw_req_if import ptw_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/ptw_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_rsp_if
// Result channel: memory read requests and finished translations.
// ----------------------------------------------------------------------------
interface ptw_rsp_if import ptw_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/ptw_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_in_reg
// Input register stage; holds one request transfer until the walk stage takes it.
// ----------------------------------------------------------------------------
module ptw_in_reg import ptw_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ptw_req_if.sink   req_if,
   input  logic      advance,
   output logic      stage_valid,
   output req_type   stage_data
);

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    take;

   assign req_if.ready = !valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_if.data;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

endmodule

// ===== rtl/core/ptw_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_walk
// Walk state, one-level entry decode and the result register.
// ----------------------------------------------------------------------------
module ptw_walk import ptw_pkg::*; #(
   parameter int PHYS_ADDR_BITS = 36
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      stage_valid,
   input  req_type   stage_data,
   output logic      advance,
   ptw_rsp_if.source rsp_if
);

   localparam logic [ENTRY_BITS-1:0] PHYS_MASK =
      (64'd1 << PHYS_ADDR_BITS) - 64'd1;
   localparam logic [ENTRY_BITS-1:0] FRAME_4K = PHYS_MASK & ~OFFSET_4K_MASK;
   localparam logic [ENTRY_BITS-1:0] FRAME_2M = PHYS_MASK & ~OFFSET_2M_MASK;
   localparam logic [ENTRY_BITS-1:0] FRAME_1G = PHYS_MASK & ~OFFSET_1G_MASK;

   logic                      busy_ff, busy_in;
   logic [1:0]                level_ff, level_in;
   logic [VIRT_ADDR_BITS-1:0] va_ff, va_in;
   logic                      out_valid_ff, out_valid_in;
   rsp_type                   out_data_ff, out_data_in;

   logic                      fire;
   logic                      load;
   logic [IDX_BITS-1:0]       next_idx;
   logic [RA_BITS-1:0]        root_addr;
   logic [ENTRY_BITS-1:0]     entry;
   logic [ENTRY_BITS-1:0]     table_addr;
   logic [ENTRY_BITS-1:0]     pa_1g, pa_2m, pa_4k;
   logic                      entry_bad;

   assign advance = !out_valid_ff || rsp_if.ready;
   assign fire    = stage_valid && advance;
   assign entry   = stage_data.read_data;

   assign root_addr = {stage_data.table_root[RA_BITS-1:4], 4'b0000}
                    + {{(RA_BITS-IDX_BITS-3){1'b0}},
                       stage_data.virtual_address[47:39], 3'b000};

   always_comb begin
      case (level_ff)
         LVL_PML4: next_idx = va_ff[38:30];
         LVL_PDPT: next_idx = va_ff[29:21];
         default:  next_idx = va_ff[20:12];
      endcase
   end

   assign table_addr = (entry & FRAME_4K)
                     | {{(ENTRY_BITS-IDX_BITS-3){1'b0}}, next_idx, 3'b000};
   assign pa_1g = (entry & FRAME_1G) | ({16'd0, va_ff} & OFFSET_1G_MASK);
   assign pa_2m = (entry & FRAME_2M) | ({16'd0, va_ff} & OFFSET_2M_MASK);
   assign pa_4k = (entry & FRAME_4K) | ({16'd0, va_ff} & OFFSET_4K_MASK);
   assign entry_bad = stage_data.read_error || !entry[ENTRY_PRESENT_BIT];

   always_comb begin
      busy_in     = busy_ff;
      level_in    = level_ff;
      va_in       = va_ff;
      load        = 1'b0;
      out_data_in = '0;
      if (fire) begin
         if (stage_data.action == ACT_REQUEST) begin
            busy_in                  = 1'b1;
            level_in                 = LVL_PML4;
            va_in                    = stage_data.virtual_address;
            load                     = 1'b1;
            out_data_in.kind         = KIND_READ;
            out_data_in.read_address = root_addr;
         end else if (busy_ff) begin
            load = 1'b1;
            if (entry_bad) begin
               busy_in           = 1'b0;
               level_in          = LVL_PML4;
               out_data_in.kind  = KIND_DONE;
               out_data_in.fault = 1'b1;
            end else begin
               case (level_ff)
                  LVL_PML4: begin
                     level_in                 = LVL_PDPT;
                     out_data_in.kind         = KIND_READ;
                     out_data_in.read_address = table_addr[RA_BITS-1:0];
                  end
                  LVL_PDPT, LVL_PD: begin
                     if (entry[ENTRY_PS_BIT]) begin
                        busy_in                      = 1'b0;
                        level_in                     = LVL_PML4;
                        out_data_in.kind             = KIND_DONE;
                        if (level_ff == LVL_PDPT) begin
                           out_data_in.physical_address = pa_1g[PA_BITS-1:0];
                           out_data_in.map_size         = PS_1G;
                        end else begin
                           out_data_in.physical_address = pa_2m[PA_BITS-1:0];
                           out_data_in.map_size         = PS_2M;
                        end
                     end else begin
                        level_in                 = level_ff + 2'd1;
                        out_data_in.kind         = KIND_READ;
                        out_data_in.read_address = table_addr[RA_BITS-1:0];
                     end
                  end
                  default: begin
                     busy_in                      = 1'b0;
                     level_in                     = LVL_PML4;
                     out_data_in.kind             = KIND_DONE;
                     out_data_in.physical_address = pa_4k[PA_BITS-1:0];
                     out_data_in.map_size         = PS_4K;
                  end
               endcase
            end
         end
      end
      if (load) begin
         out_valid_in = 1'b1;
      end else if (advance) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         level_ff     <= LVL_PML4;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         level_ff     <= level_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff <= va_in;
      if (load) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.data  = out_data_ff;

   // terse checks on walk bookkeeping
   a_fault_ends_walk: assert property (@(posedge clock) disable iff (reset)
      load && out_data_in.kind == KIND_DONE |=> !busy_ff && level_ff == LVL_PML4)
      else $error("walk still busy after finished transfer");

   a_read_keeps_walk: assert property (@(posedge clock) disable iff (reset)
      load && out_data_in.kind == KIND_READ |=> busy_ff)
      else $error("walk idle after read request");

   a_idle_rsp_ignored: assert property (@(posedge clock) disable iff (reset)
      fire && stage_data.action == ACT_RESPONSE && !busy_ff |=> !busy_ff)
      else $error("response while idle started a walk");

   a_size_only_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.map_size != PS_4K
      |-> out_data_ff.kind == KIND_DONE && !out_data_ff.fault)
      else $error("page size on non-translation transfer");

endmodule

// ===== rtl/core/four_level_page_table_walker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top
// Four-level page-table walker for 48-bit linear addresses.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries either a new translation (action 0: table root and
//   linear address) or the entry returned for the last read (action 1).
//   rsp_if returns either the address of the next 8-byte entry to read
//   (kind 0) or the finished translation with fault and page size (kind 1).
//   Each req transfer produces at most one rsp transfer, registered in
//   the input register and then the result register; a response that
//   arrives with no walk open gives nothing.
//   One req transfer can be taken every cycle while rsp_if.ready is high:
//   an input register and a result register hold one transfer each, and
//   the walk stage decodes one entry per cycle. A full walk costs four
//   memory round trips at most, set by the external memory latency.
//   A new translation while a walk is open drops the open walk.
//   Reset (synchronous) empties both registers and closes any walk.
//   If rsp_if.ready is low the result register holds its transfer and the
//   input register fills, after which req_if.ready falls.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_top import ptw_pkg::*; #(
   parameter int PHYS_ADDR_BITS = 36
) (
   input  logic      clock,
   input  logic      reset,
   ptw_req_if.sink   req_if,
   ptw_rsp_if.source rsp_if
);

   logic    advance;
   logic    stage_valid;
   req_type stage_data;

   ptw_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_data  (stage_data)
   );

   ptw_walk #(
      .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .advance     (advance),
      .rsp_if      (rsp_if)
   );

endmodule

// ===== verif/tb_four_level_page_table_walker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_level_page_table_walker_top
// Self-checking bench for the four-level page-table walker. Directed walks
// cover 4 KB, 2 MB and 1 GB pages, read errors, absent entries, address wrap,
// restarts and stray responses. Random walks then run under four idling
// phases. A local walk model predicts every read request and translation,
// and each rsp transfer is checked in order against it.
// ----------------------------------------------------------------------------
module tb_four_level_page_table_walker_top;
   import ptw_pkg::*;

   localparam int PHYS_BITS   = 36;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 300;

   logic clock;
   logic reset;

   ptw_req_if req_ch ();
   ptw_rsp_if rsp_ch ();

   four_level_page_table_walker_top #(.PHYS_ADDR_BITS(PHYS_BITS)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // mirrored walk state
   logic                      walk_open;
   logic [1:0]                walk_depth;
   logic [VIRT_ADDR_BITS-1:0] held_va;

   rsp_type     pending_rsp_q[$];
   int unsigned walk_items;
   int unsigned mismatch_count;
   int unsigned cycle_count;
   int unsigned send_idle_pct;
   int unsigned rsp_stall_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [RA_BITS-1:0] entry_slot(input logic [RA_BITS-1:0] table_base,
                                                     input logic [IDX_BITS-1:0] idx);
      return table_base + {idx, 3'b000};
   endfunction

   function automatic logic [RA_BITS-1:0] frame_4k(input logic [ENTRY_BITS-1:0] entry);
      logic [RA_BITS-1:0] base;
      base = '0;
      base[PHYS_BITS-1:12] = entry[PHYS_BITS-1:12];
      return base;
   endfunction

   // advances the mirrored walk by one accepted transfer
   function automatic void predict_walk(input req_type it, output logic produced,
                                        output rsp_type want);
      logic [PA_BITS-1:0]    pa;
      logic [ENTRY_BITS-1:0] entry;
      logic                  finished;
      produced = 1'b1;
      finished = 1'b0;
      want     = '0;
      pa       = '0;
      entry    = it.read_data;
      want.kind = KIND_READ;
      if (it.action == ACT_REQUEST) begin
         held_va    = it.virtual_address;
         walk_open  = 1'b1;
         walk_depth = LVL_PML4;
         want.read_address = entry_slot({it.table_root[RA_BITS-1:4], 4'b0000},
                                        held_va[47:39]);
      end else if (!walk_open) begin
         produced = 1'b0;
      end else if (it.read_error || !entry[ENTRY_PRESENT_BIT]) begin
         finished   = 1'b1;
         want.fault = 1'b1;
      end else begin
         case (walk_depth)
            LVL_PML4: begin
               walk_depth = LVL_PDPT;
               want.read_address = entry_slot(frame_4k(entry), held_va[38:30]);
            end
            LVL_PDPT: begin
               if (entry[ENTRY_PS_BIT]) begin
                  finished = 1'b1;
                  pa[PHYS_BITS-1:0] = {entry[PHYS_BITS-1:30], held_va[29:0]};
                  want.map_size = PS_1G;
               end else begin
                  walk_depth = LVL_PD;
                  want.read_address = entry_slot(frame_4k(entry), held_va[29:21]);
               end
            end
            LVL_PD: begin
               if (entry[ENTRY_PS_BIT]) begin
                  finished = 1'b1;
                  pa[PHYS_BITS-1:0] = {entry[PHYS_BITS-1:21], held_va[20:0]};
                  want.map_size = PS_2M;
               end else begin
                  walk_depth = LVL_PT;
                  want.read_address = entry_slot(frame_4k(entry), held_va[20:12]);
               end
            end
            default: begin
               finished = 1'b1;
               pa[PHYS_BITS-1:0] = {entry[PHYS_BITS-1:12], held_va[11:0]};
               want.map_size = PS_4K;
            end
         endcase
      end
      if (finished) begin
         want.kind             = KIND_DONE;
         want.physical_address = pa;
         walk_open             = 1'b0;
         walk_depth            = LVL_PML4;
      end
   endfunction

   function automatic req_type random_fields();
      req_type it;
      it.action          = 1'($urandom_range(1));
      it.table_root      = RA_BITS'({$urandom, $urandom});
      it.virtual_address = VIRT_ADDR_BITS'({$urandom, $urandom});
      it.read_data       = {$urandom, $urandom};
      it.read_error      = 1'($urandom_range(1));
      return it;
   endfunction

   function automatic req_type request_item(input logic [RA_BITS-1:0] root,
                                            input logic [VIRT_ADDR_BITS-1:0] va);
      req_type it;
      it = random_fields();
      it.action          = ACT_REQUEST;
      it.table_root      = root;
      it.virtual_address = va;
      return it;
   endfunction

   function automatic req_type random_request();
      return request_item(RA_BITS'({$urandom, $urandom}),
                          VIRT_ADDR_BITS'({$urandom, $urandom}));
   endfunction

   function automatic req_type response_item(input logic [ENTRY_BITS-1:0] entry,
                                             input logic err);
      req_type it;
      it = random_fields();
      it.action     = ACT_RESPONSE;
      it.read_data  = entry;
      it.read_error = err;
      return it;
   endfunction

   function automatic logic [ENTRY_BITS-1:0] present_entry(input logic ps);
      logic [ENTRY_BITS-1:0] entry;
      entry = {$urandom, $urandom};
      entry[ENTRY_PRESENT_BIT] = 1'b1;
      entry[ENTRY_PS_BIT]      = ps;
      return entry;
   endfunction

   task automatic send_item(input req_type it);
      logic    produced;
      rsp_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= it;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_walk(it, produced, want);
      if (produced) begin
         pending_rsp_q.push_back(want);
         walk_items++;
      end
   endtask

   task automatic report_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"%0t %s: exp kind=%0d ra=%h pa=%h fault=%0d ps=%0d,",
                   " got kind=%0d ra=%h pa=%h fault=%0d ps=%0d"},
                  $realtime, what, want.kind, want.read_address, want.physical_address,
                  want.fault, want.map_size, got.kind, got.read_address,
                  got.physical_address, got.fault, got.map_size);
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("unexpected transfer", '0, rsp_ch.data);
         end else begin
            want = pending_rsp_q.pop_front();
            if (want.kind !== rsp_ch.data.kind
                || want.read_address !== rsp_ch.data.read_address
                || want.physical_address !== rsp_ch.data.physical_address
                || want.fault !== rsp_ch.data.fault
                || want.map_size !== rsp_ch.data.map_size)
               report_mismatch("mismatch", want, rsp_ch.data);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL four_level_page_table_walker_top");
         $finish;
      end
   end

   // root wraps at 36 bits, entry bits above the frame and PS at top/bottom ignored
   task automatic test_four_k_walk();
      send_item(request_item(36'hF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF));
      send_item(response_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
      send_item(response_item(64'hFFFF_FFFF_FFFF_FF7F, 1'b0));
      send_item(response_item(64'hFFFF_FFFF_FFFF_FF7F, 1'b0));
      send_item(response_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
      send_item(request_item('0, '0));
      repeat (4) send_item(response_item(64'h1, 1'b0));
   endtask

   task automatic test_large_pages();
      send_item(random_request());
      send_item(response_item(present_entry(1'b0), 1'b0));
      send_item(response_item(present_entry(1'b1), 1'b0));
      send_item(random_request());
      send_item(response_item(present_entry(1'b1), 1'b0));
      send_item(response_item(present_entry(1'b0), 1'b0));
      send_item(response_item(present_entry(1'b1), 1'b0));
   endtask

   task automatic test_faults();
      send_item(random_request());
      send_item(response_item(present_entry(1'b0), 1'b1));
      send_item(random_request());
      repeat (3) send_item(response_item(present_entry(1'b0), 1'b0));
      send_item(response_item(present_entry(1'b0) & ~64'h1, 1'b0));
   endtask

   // stray response while idle, then a new request dropping an open walk
   task automatic test_restart_and_stray();
      send_item(response_item(present_entry(1'b0), 1'b0));
      send_item(random_request());
      send_item(response_item(present_entry(1'b0), 1'b0));
      send_item(random_request());
      send_item(response_item(present_entry(1'b0), 1'b0));
   endtask

   task automatic random_walk();
      req_type     it;
      int unsigned pick;
      it = random_fields();
      it.action = ACT_REQUEST;
      send_item(it);
      while (walk_open) begin
         pick = $urandom_range(99);
         if (pick < 4)
            return;
         it = random_fields();
         it.action     = ACT_RESPONSE;
         it.read_error = (pick < 8);
         if (pick >= 8)
            it.read_data[ENTRY_PRESENT_BIT] = (pick >= 12);
         it.read_data[ENTRY_PS_BIT] = ($urandom_range(99) < 40);
         send_item(it);
      end
      if ($urandom_range(99) < 10) begin
         it = random_fields();
         it.action = ACT_RESPONSE;
         send_item(it);
      end
   endtask

   task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
      int unsigned start_items;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      start_items   = walk_items;
      while (walk_items - start_items < PHASE_ITEMS) random_walk();
   endtask

   task automatic test_random_walks();
      run_random_phase(0, 0);
      run_random_phase(59, 0);
      run_random_phase(0, 59);
      run_random_phase(26, 26);
   endtask

   initial begin
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      walk_open     = 1'b0;
      walk_depth    = LVL_PML4;
      held_va       = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_four_k_walk();
      test_large_pages();
      test_faults();
      test_restart_and_stray();
      test_random_walks();

      req_ch.valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
         $display("PASS four_level_page_table_walker_top");
      end else begin
         $display("FAIL four_level_page_table_walker_top");
      end
      $finish;
   end

endmodule
